[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/xsr_pkg.sv]
// ----------------------------------------------------------------------------
// xsr_pkg
// Types, constants and helpers of the bounded xorshift64* generator.
// ----------------------------------------------------------------------------
package xsr_pkg;

  localparam int unsigned StateW = 64;
  localparam int unsigned ValueW = 48;
  localparam int unsigned ResW   = 53;
  localparam int unsigned DivSteps = 64;

  localparam logic [63:0] MixGold = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MixMul1 = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MixMul2 = 64'h94D049BB133111EB;
  localparam logic [63:0] StarMul = 64'h2545F4914F6CDD1D;

  typedef enum logic [1:0] {
    KIND_RESEED = 2'd0,
    KIND_INT    = 2'd1,
    KIND_FRAC   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CSEL_MIX1 = 2'd0,
    CSEL_MIX2 = 2'd1,
    CSEL_STAR = 2'd2
  } csel_t;

  typedef enum logic [1:0] {
    FIN_ZERO = 2'd0,
    FIN_BAD  = 2'd1,
    FIN_FRAC = 2'd2,
    FIN_REM  = 2'd3
  } fin_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SEED_USR,
    OP_SEED_DEF,
    OP_XS30,
    OP_XS27,
    OP_XS31_ST,
    OP_STEP,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_MUL3,
    OP_DIV_THR,
    OP_DIV_X,
    OP_DIV_STEP,
    OP_THR_SAVE
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_THR,
    S_THRSV,
    S_PRE,
    S_MX30,
    S_MX27,
    S_MX31,
    S_MUL,
    S_DRAW,
    S_CHK,
    S_MOD,
    S_FIN
  } state_t;

  typedef struct packed {
    op_t   op;
    csel_t csel;
    logic  load;
    logic  out_load;
    fin_t  fin;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  bound_bad;
    logic  draw_lt;
    logic  state_zero;
  } dp_flags_t;

  function automatic logic [63:0] mul_const(csel_t c);
    logic [63:0] r;
    unique case (c)
      CSEL_MIX1: r = MixMul1;
      CSEL_MIX2: r = MixMul2;
      default:   r = StarMul;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] xs_step(logic [63:0] s);
    logic [63:0] x;
    x = s ^ (s >> 12);
    x = x ^ (x << 25);
    x = x ^ (x >> 27);
    return x;
  endfunction

endpackage

[rtl/core/xsr_datapath.sv]
// ----------------------------------------------------------------------------
// xsr_datapath
// Generator state, shared 32x32 multiplier, bit-serial remainder unit and
// output register.
// ----------------------------------------------------------------------------
module xsr_datapath import xsr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [63:0]         cfg_data,
  input  logic [1:0]          kind,
  input  logic signed [47:0]  value,
  input  dp_cmd_t             cmd,
  output dp_flags_t           flags,
  output logic                status,
  output logic [ResW-1:0]     result_value
);

  logic [63:0] default_seed;
  logic [63:0] gen_state;
  logic [63:0] x;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [63:0] sh;
  logic [47:0] rem;
  logic [47:0] thr;
  logic [47:0] vin;
  kind_t       kin;

  logic [63:0] cval;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [48:0] r2;
  logic        ge;
  logic [48:0] r2_sub;
  logic [63:0] vext;

  assign cval = mul_const(cmd.csel);
  assign vext = {{16{vin[47]}}, vin};
  assign r2 = {rem, sh[63]};
  assign ge = r2 >= {1'b0, vin};
  assign r2_sub = r2 - {1'b0, vin};

  always_comb begin
    ma = x[31:0];
    mb = cval[31:0];
    unique case (cmd.op)
      OP_MUL1: mb = cval[63:32];
      OP_MUL2: ma = x[63:32];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_seed <= '0;
      gen_state <= '0;
    end else begin
      if (cfg_we) default_seed <= cfg_data;
      if (cmd.op == OP_XS31_ST) gen_state <= x ^ (x >> 31);
      if (cmd.op == OP_STEP) gen_state <= xs_step(gen_state);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vin <= value;
      kin <= kind_t'(kind);
    end
    unique case (cmd.op)
      OP_SEED_USR: x <= vext + MixGold;
      OP_SEED_DEF: x <= default_seed + MixGold;
      OP_XS30:     x <= x ^ (x >> 30);
      OP_XS27:     x <= x ^ (x >> 27);
      OP_STEP:     x <= xs_step(gen_state);
      OP_MUL0:     prod <= ma * mb;
      OP_MUL1: begin
        acc  <= prod;
        prod <= ma * mb;
      end
      OP_MUL2: begin
        acc  <= acc + {prod[31:0], 32'd0};
        prod <= ma * mb;
      end
      OP_MUL3:     x <= acc + {prod[31:0], 32'd0};
      OP_DIV_THR: begin
        sh  <= 64'd0 - vext;
        rem <= '0;
      end
      OP_DIV_X: begin
        sh  <= x;
        rem <= '0;
      end
      OP_DIV_STEP: begin
        sh  <= {sh[62:0], 1'b0};
        rem <= ge ? r2_sub[47:0] : r2[47:0];
      end
      OP_THR_SAVE: thr <= rem;
      default: ;
    endcase
    if (cmd.out_load) begin
      unique case (cmd.fin)
        FIN_BAD: begin
          status <= 1'b1;
          result_value <= '0;
        end
        FIN_FRAC: begin
          status <= 1'b0;
          result_value <= x[63:11];
        end
        FIN_REM: begin
          status <= 1'b0;
          result_value <= {5'd0, rem};
        end
        default: begin
          status <= 1'b0;
          result_value <= '0;
        end
      endcase
    end
  end

  assign flags.kind       = kin;
  assign flags.bound_bad  = vin[47] || (vin == '0);
  assign flags.draw_lt    = x < {16'd0, thr};
  assign flags.state_zero = gen_state == '0;

endmodule

[rtl/core/xsr_ctrl.sv]
// ----------------------------------------------------------------------------
// xsr_ctrl
// Sequencer: seeding, threshold and remainder passes, rejection loop and
// output handshake.
// ----------------------------------------------------------------------------
module xsr_ctrl import xsr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  dp_flags_t flags,
  output dp_cmd_t   cmd
);

  state_t     state, state_next;
  state_t     ret, ret_next;
  csel_t      csel, csel_next;
  fin_t       fin, fin_next;
  logic [5:0] cnt, cnt_next;
  logic [1:0] ph, ph_next;
  logic       seeded, seeded_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      csel      <= CSEL_MIX1;
      fin       <= FIN_ZERO;
      cnt       <= '0;
      ph        <= '0;
      seeded    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      csel      <= csel_next;
      fin       <= fin_next;
      cnt       <= cnt_next;
      ph        <= ph_next;
      seeded    <= seeded_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    ret_next       = ret;
    csel_next      = csel;
    fin_next       = fin;
    cnt_next       = cnt;
    ph_next        = ph;
    seeded_next    = seeded;
    out_valid_next = out_valid && out_stall;
    in_stall       = state != S_IDLE;
    cmd            = '{op: OP_NONE, csel: csel, load: 1'b0, out_load: 1'b0, fin: fin};

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        unique case (flags.kind)
          KIND_RESEED: begin
            cmd.op     = OP_SEED_USR;
            state_next = S_MX30;
          end
          KIND_INT: begin
            if (flags.bound_bad) begin
              fin_next   = FIN_BAD;
              state_next = S_FIN;
            end else begin
              cmd.op     = OP_DIV_THR;
              cnt_next   = '0;
              state_next = S_THR;
            end
          end
          KIND_FRAC: state_next = S_PRE;
          default: begin
            fin_next   = FIN_ZERO;
            state_next = S_FIN;
          end
        endcase
      end
      S_THR: begin
        cmd.op   = OP_DIV_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(DivSteps - 1)) state_next = S_THRSV;
      end
      S_THRSV: begin
        cmd.op     = OP_THR_SAVE;
        state_next = S_PRE;
      end
      S_PRE: begin
        if (!seeded) begin
          cmd.op     = OP_SEED_DEF;
          state_next = S_MX30;
        end else begin
          state_next = S_DRAW;
        end
      end
      S_MX30: begin
        cmd.op     = OP_XS30;
        csel_next  = CSEL_MIX1;
        ret_next   = S_MX27;
        ph_next    = '0;
        state_next = S_MUL;
      end
      S_MX27: begin
        cmd.op     = OP_XS27;
        csel_next  = CSEL_MIX2;
        ret_next   = S_MX31;
        ph_next    = '0;
        state_next = S_MUL;
      end
      S_MX31: begin
        cmd.op      = OP_XS31_ST;
        seeded_next = 1'b1;
        if (flags.kind == KIND_RESEED) begin
          fin_next   = FIN_ZERO;
          state_next = S_FIN;
        end else begin
          state_next = S_DRAW;
        end
      end
      S_MUL: begin
        unique case (ph)
          2'd0:    cmd.op = OP_MUL0;
          2'd1:    cmd.op = OP_MUL1;
          2'd2:    cmd.op = OP_MUL2;
          default: cmd.op = OP_MUL3;
        endcase
        ph_next = ph + 2'd1;
        if (ph == 2'd3) state_next = ret;
      end
      S_DRAW: begin
        cmd.op     = OP_STEP;
        csel_next  = CSEL_STAR;
        ret_next   = S_CHK;
        ph_next    = '0;
        state_next = S_MUL;
      end
      S_CHK: begin
        if (flags.kind == KIND_FRAC) begin
          fin_next   = FIN_FRAC;
          state_next = S_FIN;
        end else if (flags.draw_lt && !flags.state_zero) begin
          state_next = S_DRAW;
        end else begin
          cmd.op     = OP_DIV_X;
          cnt_next   = '0;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.op   = OP_DIV_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(DivSteps - 1)) begin
          fin_next   = FIN_REM;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/core/xorshift64star_bounded_rng.sv]
// ----------------------------------------------------------------------------
// xorshift64star_bounded_rng
// Bounded xorshift64* generator: reseed, bounded integer and fraction draws.
// ----------------------------------------------------------------------------
// One request at a time: a reseed, a fraction draw or a bounded integer
// draw. A draw first seeds from default_seed when no seed has been set. A
// bounded integer draw runs two 64-step bit-serial remainder passes and
// repeats the draw for each rejected value, and each draw uses the shared
// 32x32 multiplier. A bad bound and an unused kind answer straight from
// decode. The result sits in an output register, so a new request is taken
// in the cycle after the result is loaded, even while that transfer is
// still stalled; the result is loaded only once the output register is free.
module xorshift64star_bounded_rng import xsr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic signed [47:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic [ResW-1:0]    result_value
);

  dp_cmd_t   cmd;
  dp_flags_t flags;

  xsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flags     (flags),
    .cmd       (cmd)
  );

  xsr_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .kind         (kind),
    .value        (value),
    .cmd          (cmd),
    .flags        (flags),
    .status       (status),
    .result_value (result_value)
  );

endmodule

[rtl/core/xsr_checker.sv]
// ----------------------------------------------------------------------------
// xsr_checker
// Port-level checks of the bounded generator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xsr_checker import xsr_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic            status,
  input logic [ResW-1:0] result_value
);

  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid, "result dropped")
  `ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !out_valid, "result valid after reset")
  `ASSERT_CLK(a_bad_zero, clk, rst, out_valid && status |-> result_value == '0, "nonzero error value")
  `ASSERT_CLK(a_busy, clk, rst, in_valid && !in_stall |=> in_stall, "second request taken while busy")

endmodule

bind xorshift64star_bounded_rng xsr_checker u_xsr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .result_value (result_value)
);
